>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/slit_pkg.sv
// ----------------------------------------------------------------------------
// slit_pkg
// Types and constants of the sorted leaf table.
// ----------------------------------------------------------------------------
package slit_pkg;

  localparam int MAX_CELLS    = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int KEY_W        = 64;
  localparam int PAY_W        = 64;
  localparam int IDX_W        = $clog2(MAX_CELLS);
  localparam int CNT_W        = $clog2(MAX_CELLS + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [3:0]       cell_index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [4:0]       cell_count;
    logic [3:0]       slot;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
  } cell_data_t;

  typedef struct packed {
    logic       ins_en;
    cell_data_t data;
  } bcast_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_stat_t;

endpackage

>>> hdl/sorted_leaf_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_leaf_insert_table
// One B-tree leaf of up to MAX_CELLS key/payload cells kept in key order.
//
// Request channel req (req_valid/req_stall) carries mode, key, payload and
// cell_index; response channel rsp (rsp_valid/rsp_stall) returns status,
// out_key, out_payload, cell_count and slot, one response per request.
// A transfer happens when valid is high and stall is low.
// Every cell compares its key with the request key in the same cycle and
// the row shifts by one cell on insert, so while req_stall is low one request
// is done per cycle: the response is registered and shows in the cycle after
// the transfer, and a new request can transfer every cycle. The compare
// across the row and the slot encode set the cycle time.
// While the response register holds an untaken response and rsp_stall is
// high, req_stall is high and the table does not change.
// Reset empties the node (count zero) and drops any pending response.
// Cell contents are not cleared; only cells below the count are read.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_table import slit_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cnt_m1;
  logic             accept;
  logic             full;
  logic             dup;
  logic             ins_ok;
  logic [MAX_CELLS-1:0] lt_vec;
  logic [MAX_CELLS-1:0] eq_vec;
  logic [MAX_CELLS-1:0] first_ge;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] sel;
  bcast_t           bc;
  cell_data_t       cells [MAX_CELLS];
  cell_stat_t       stats [MAX_CELLS];
  cell_data_t       rd;
  rsp_t             res;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (cnt == CNT_W'(MAX_CELLS));
  assign dup       = |eq_vec;
  assign ins_ok    = accept && (req.mode == MODE_INSERT) && !full && !dup;
  assign cnt_m1    = cnt - CNT_W'(1);

  assign bc.ins_en       = ins_ok;
  assign bc.data.key     = req.key;
  assign bc.data.payload = req.payload[PAYLOAD_BITS-1:0];

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      slit_cell u_cell (
        .clk     (clk),
        .bc      (bc),
        .valid   (cnt > CNT_W'(i)),
        .left_lt (1'b1),
        .left    (bc.data),
        .data    (cells[i]),
        .stat    (stats[i])
      );
    end else begin : g_body
      slit_cell u_cell (
        .clk     (clk),
        .bc      (bc),
        .valid   (cnt > CNT_W'(i)),
        .left_lt (stats[i-1].lt),
        .left    (cells[i-1]),
        .data    (cells[i]),
        .stat    (stats[i])
      );
    end
    assign lt_vec[i] = stats[i].lt;
    assign eq_vec[i] = stats[i].eq;
    assign first_ge[i] = !lt_vec[i] && ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]);
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      if (first_ge[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign sel = (req.mode == MODE_READ) ? req.cell_index[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign rd  = cells[sel];

  always_comb begin
    res             = '0;
    res.status      = ST_OK;
    unique case (req.mode)
      MODE_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (dup) begin
          res.status = ST_DUP;
          res.slot   = 4'(pos);
        end else begin
          res.slot   = 4'(pos);
        end
      end
      MODE_READ: begin
        if (CNT_W'(req.cell_index) >= cnt) begin
          res.status = ST_RANGE;
        end else begin
          res.out_key     = rd.key;
          res.out_payload = PAY_W'(rd.payload);
          res.slot        = req.cell_index;
        end
      end
      MODE_MAX: begin
        if (cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_key = rd.key;
          res.slot    = 4'(cnt_m1[IDX_W-1:0]);
        end
      end
      MODE_CLEAR: begin
      end
      default: begin
      end
    endcase
    res.cell_count = 5'(cnt_next);
  end

  always_comb begin
    cnt_next = cnt;
    if (accept && (req.mode == MODE_CLEAR)) begin
      cnt_next = '0;
    end else if (ins_ok) begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= res;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_cnt_range, cnt <= CNT_W'(MAX_CELLS), "cell count beyond capacity")
  `ASSERT_CLK(a_ins_grow, ins_ok |=> (cnt == $past(cnt) + CNT_W'(1)), "insert did not grow count")
  `ASSERT_CLK(a_clear, (accept && (req.mode == MODE_CLEAR)) |=> (cnt == '0) && rsp_valid, "clear failed")
  `ASSERT_ALL(a_rst, rst |=> !rsp_valid && (cnt == '0), "reset left state")

endmodule

>>> hdl/slit_cell.sv
// ----------------------------------------------------------------------------
// slit_cell
// One table cell: compares its key with the broadcast key and, on insert,
// keeps its entry, takes the new entry, or takes its left neighbor's.
// ----------------------------------------------------------------------------
module slit_cell import slit_pkg::*; (
  input  logic       clk,
  input  bcast_t     bc,
  input  logic       valid,
  input  logic       left_lt,
  input  cell_data_t left,
  output cell_data_t data,
  output cell_stat_t stat
);

  assign stat.lt = valid && (data.key < bc.data.key);
  assign stat.eq = valid && (data.key == bc.data.key);

  always_ff @(posedge clk) begin
    if (bc.ins_en && !stat.lt) begin
      data <= left_lt ? bc.data : left;
    end
  end

endmodule

>>> verif/sorted_leaf_insert_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_leaf_insert_table_tb
// Self-checking bench for the sorted B-tree leaf table.
//
// A directed table covers the empty node, the duplicate key, a shifting
// fill to a full node and rejects on a full node. Random traffic follows,
// mostly inserts with colliding keys so that the node fills often, mixed
// with reads, max and clear. Both channels idle at random. An in-bench
// model of the leaf predicts each response that the directed table does not give.
// ----------------------------------------------------------------------------
module sorted_leaf_insert_table_tb;
  import slit_pkg::*;

  localparam int WD_LIMIT   = 2000;
  localparam int SEG_ITEMS  = 300;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    req_t r;
    bit   typed;
    rsp_t exp;
  } leaf_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // tag that travels with the driven request
  bit   row_typed = 1'b0;
  rsp_t row_exp = '0;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  // leaf model state
  logic [KEY_W-1:0]        leaf_keys [MAX_CELLS];
  logic [PAYLOAD_BITS-1:0] leaf_pays [MAX_CELLS];
  int                      leaf_count = 0;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   accepted = 0;
  int   checked = 0;
  int   status_hits [5] = '{default: 0};
  int   idle_cycles = 0;

  sorted_leaf_insert_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t leaf_apply(req_t r);
    rsp_t o;
    int   pos;
    int   i;
    o = '0;
    o.status = ST_OK;
    case (r.mode)
      MODE_INSERT: begin
        if (leaf_count >= MAX_CELLS) begin
          o.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < leaf_count && leaf_keys[pos] < r.key) pos++;
          if (pos < leaf_count && leaf_keys[pos] == r.key) begin
            o.status = ST_DUP;
            o.slot = pos[3:0];
          end else begin
            for (i = leaf_count; i > pos; i--) begin
              leaf_keys[i] = leaf_keys[i-1];
              leaf_pays[i] = leaf_pays[i-1];
            end
            leaf_keys[pos] = r.key;
            leaf_pays[pos] = r.payload[PAYLOAD_BITS-1:0];
            leaf_count++;
            o.slot = pos[3:0];
          end
        end
      end
      MODE_READ: begin
        if (int'(r.cell_index) >= leaf_count) begin
          o.status = ST_RANGE;
        end else begin
          o.out_key = leaf_keys[r.cell_index];
          o.out_payload = PAY_W'(leaf_pays[r.cell_index]);
          o.slot = r.cell_index;
        end
      end
      MODE_MAX: begin
        if (leaf_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.out_key = leaf_keys[leaf_count-1];
          o.slot = 4'(leaf_count - 1);
        end
      end
      default: begin
        leaf_count = 0;
      end
    endcase
    o.cell_count = 5'(leaf_count);
    return o;
  endfunction

  function automatic req_t mk_req(mode_t m, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                  logic [3:0] idx);
    req_t r;
    r.mode = m;
    r.key = k;
    r.payload = p;
    r.cell_index = idx;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_t s, logic [KEY_W-1:0] k, logic [4:0] cnt,
                                  logic [3:0] sl);
    rsp_t o;
    o.status = s;
    o.out_key = k;
    o.out_payload = '0;
    o.cell_count = cnt;
    o.slot = sl;
    return o;
  endfunction

  function automatic req_t make_random_req();
    req_t r;
    int   v;
    v = $urandom_range(0, 99);
    if (v < 58) r.mode = MODE_INSERT;
    else if (v < 88) r.mode = MODE_READ;
    else if (v < 98) r.mode = MODE_MAX;
    else r.mode = MODE_CLEAR;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (leaf_count > 0) r.key = leaf_keys[$urandom_range(0, leaf_count - 1)];
        else r.key = {$urandom, $urandom};
      end
      3, 4, 5: begin
        r.key = 64'($urandom_range(0, 31));
        if ($urandom_range(0, 1)) r.key = ~r.key;
      end
      default: r.key = {$urandom, $urandom};
    endcase
    r.payload = {$urandom, $urandom};
    r.cell_index = 4'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_row(input leaf_row_t row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= row.r;
    row_typed <= row.typed;
    row_exp   <= row.exp;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // response side: random stall per transfer, one long hold on request
  initial begin
    int k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        k = quiet ? 0 : $urandom_range(0, 11);
        if (k > 0) begin
          rsp_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: response with none expected, got %h", $time, rsp);
          mismatches++;
        end else begin
          want = pending_rsp.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("out_key", want.out_key, rsp.out_key);
          check_field("out_payload", want.out_payload, rsp.out_payload);
          check_field("cell_count", 64'(want.cell_count), 64'(rsp.cell_count));
          check_field("slot", 64'(want.slot), 64'(rsp.slot));
          checked++;
        end
      end
      if (req_valid && !req_stall) begin
        want = leaf_apply(req);
        if (row_typed) want = row_exp;
        pending_rsp.push_back(want);
        if (want.status <= ST_RANGE) status_hits[want.status]++;
        accepted++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    leaf_row_t rows [$];
    int        i;
    int        seg;

    rows.push_back('{mk_req(MODE_MAX, '1, '1, 4'd0), 1'b1, mk_rsp(ST_EMPTY, '0, 5'd0, 4'd0)});
    rows.push_back('{mk_req(MODE_READ, '0, '0, 4'd15), 1'b1,
                     mk_rsp(ST_RANGE, '0, 5'd0, 4'd0)});
    rows.push_back('{mk_req(MODE_INSERT, 64'h8000_0000_0000_0000, '1, 4'd0), 1'b1,
                     mk_rsp(ST_OK, '0, 5'd1, 4'd0)});
    rows.push_back('{mk_req(MODE_INSERT, 64'h8000_0000_0000_0000, '0, 4'd0), 1'b1,
                     mk_rsp(ST_DUP, '0, 5'd1, 4'd0)});
    rows.push_back('{mk_req(MODE_CLEAR, '1, '1, 4'd15), 1'b1, mk_rsp(ST_OK, '0, 5'd0, 4'd0)});
    rows.push_back('{mk_req(MODE_READ, '0, '0, 4'd0), 1'b1, mk_rsp(ST_RANGE, '0, 5'd0, 4'd0)});
    // descending keys shift the whole row on every insert, all ones down to zero
    for (i = 0; i < MAX_CELLS; i++)
      rows.push_back('{mk_req(MODE_INSERT, 64'(15 - i) * 64'h1111_1111_1111_1111,
                              {$urandom, $urandom}, 4'(i)), 1'b0, '0});
    rows.push_back('{mk_req(MODE_INSERT, 64'd5, '1, 4'd0), 1'b1,
                     mk_rsp(ST_FULL, '0, 5'd16, 4'd0)});
    rows.push_back('{mk_req(MODE_READ, '0, '0, 4'd15), 1'b0, '0});
    rows.push_back('{mk_req(MODE_MAX, '0, '0, 4'd0), 1'b1, mk_rsp(ST_OK, '1, 5'd16, 4'd15)});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[j]) send_row(rows[j]);
    wait_drained();

    for (seg = 0; seg < 6; seg++) begin
      quiet = (seg == 2);
      if (seg == 3) hold_request = 1'b1;
      for (i = 0; i < SEG_ITEMS; i++) send_row('{make_random_req(), 1'b0, '0});
      wait_drained();
    end
    quiet = 1'b0;
    repeat (4) @(posedge clk);

    $display("%0d requests sent, %0d responses checked, %0d mismatches", accepted, checked,
             mismatches);
    $display("statuses: ok %0d, full %0d, dup %0d, empty %0d, range %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
